>>> design/c2d_pkg.sv
// Shared constants, types and helpers for the streaming 2D convolution block.
`timescale 1ns / 1ps

package c2d_pkg;

    // Field and register widths.
    localparam int PIX_W       = 8;
    localparam int WT_W        = 8;
    localparam int PROD_W      = PIX_W + WT_W;
    localparam int SUM_W       = 20;
    localparam int IMG_W_CFG   = 7;
    localparam int IMG_H_CFG   = 13;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int WTS_PER_REG = CFG_DATA_W / WT_W;

    // Tallest frame the row counter supports.
    localparam logic [IMG_H_CFG-1:0] HEIGHT_LIMIT = 13'd4096;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_KERNEL    = 4;

    // Register reset values.
    localparam logic [IMG_W_CFG-1:0]  RST_IMAGE_WIDTH  = 7'd48;
    localparam logic [IMG_H_CFG-1:0]  RST_IMAGE_HEIGHT = 13'd48;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS_LOW  = 64'd282574505115649;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHTS_HIGH = 64'd72057598332961024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WEIGHTS_LOW  = 2'd2,
        CFG_WEIGHTS_HIGH = 2'd3
    } t_cfg_idx;

    // Control handed to each window cell.
    typedef struct packed {
        logic en;
        logic shift;
    } t_cell_ctrl;

    // Control handed to the line buffer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lb_ctrl;

    // Kernel weight at a row-major position; positions past sixteen weigh zero.
    function automatic logic [WT_W-1:0] weight_at(input logic [CFG_DATA_W-1:0] lo,
                                                   input logic [CFG_DATA_W-1:0] hi,
                                                   input int idx);
        logic [WT_W-1:0] w;
        w = '0;
        if (idx < WTS_PER_REG) begin
            w = lo[WT_W*idx +: WT_W];
        end else if (idx < 2 * WTS_PER_REG) begin
            w = hi[WT_W*(idx - WTS_PER_REG) +: WT_W];
        end
        return w;
    endfunction

endpackage

>>> design/c2d_linebuf.sv
// Line buffer: one entry per image column holding the previous rows, with write bypass.
`timescale 1ns / 1ps

module c2d_linebuf
    import c2d_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int LANES = DEF_KERNEL - 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lb_ctrl                   i_ctrl,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [LANES-1:0][PIX_W-1:0] i_wr_data,
    output logic [LANES-1:0][PIX_W-1:0] o_rd_data
);

    logic [LANES-1:0][PIX_W-1:0] r_mem [DEPTH];
    logic [LANES-1:0][PIX_W-1:0] r_rd;
    logic [LANES-1:0][PIX_W-1:0] r_byp_data;
    logic                        r_byp;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // A read of the column being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_ctrl.rd_en) begin
            r_byp <= i_ctrl.wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

>>> design/c2d_cell.sv
// Window cell: one kernel column of pixels, its products and its column sum.
`timescale 1ns / 1ps

module c2d_cell
    import c2d_pkg::*;
#(
    parameter int KERNEL_DIM = DEF_KERNEL,
    localparam int CSW       = PROD_W + $clog2(KERNEL_DIM)
) (
    input  logic                            i_clk,
    input  t_cell_ctrl                      i_ctrl,
    input  logic [KERNEL_DIM-1:0][PIX_W-1:0] i_col,
    input  logic [KERNEL_DIM-1:0][WT_W-1:0]  i_wt,
    output logic [KERNEL_DIM-1:0][PIX_W-1:0] o_col,
    output logic [CSW-1:0]                   o_csum
);

    logic [KERNEL_DIM-1:0][PIX_W-1:0]  r_col;
    logic [KERNEL_DIM-1:0][PROD_W-1:0] r_prod;
    logic [CSW-1:0]                    r_csum;
    logic [CSW-1:0]                    n_csum;

    // Window column, taken from the right-hand neighbor on each pixel.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // One product per kernel row.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            for (int r = 0; r < KERNEL_DIM; r++) begin
                r_prod[r] <= PROD_W'(r_col[r] * i_wt[r]);
            end
        end
    end

    // Column sum of the registered products.
    always_comb begin
        n_csum = '0;
        for (int r = 0; r < KERNEL_DIM; r++) begin
            n_csum = n_csum + CSW'(r_prod[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_csum <= n_csum;
        end
    end

    assign o_csum = r_csum;

endmodule

>>> design/conv2d_4x4_valid_stream_top.sv
// Top level of the streaming valid-mode 2D convolution over a raster pixel stream.
//
//   Channel   Direction  Payload                                  Transaction when
//   s_axis    in         tdata[7:0] pixel, tuser frame start      i_s_axis_tvalid & o_s_axis_tready
//   m_axis    out        tdata[19:0] sum, tlast last of frame     o_m_axis_tvalid & i_m_axis_tready
//   cfg       in         i_cfg_addr index, i_cfg_wdata value      i_cfg_we
//
// One pixel is taken per clock while s_axis ready is high; each result leaves through the output register.
// The rate is set by the line buffer, which serves one read and one write per cycle,
// and by the cell chain, whose window shifts once per pixel.
// Reset is synchronous and active low; it clears counters, valid flags and the output
// skid stage and loads the register defaults. The line buffer needs no clearing pass.
// When m_axis stalls, one more result lands in the skid stage, then s_axis ready drops.
`timescale 1ns / 1ps

module conv2d_4x4_valid_stream_top
    import c2d_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int KERNEL_DIM = DEF_KERNEL
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Pixel input stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] pixel
    input  logic                   i_s_axis_tuser,   // [0] frame_start
    // Result output stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [19:0] conv_sum, [23:20] zero
    output logic                   o_m_axis_tlast    // last_of_frame
);

    localparam int K     = KERNEL_DIM;
    localparam int LANES = K - 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WCW   = CW + 1;
    localparam int WCMP  = (IMG_W_CFG > WCW) ? IMG_W_CFG : WCW;
    localparam int KB    = $clog2(K);
    localparam int CSW   = PROD_W + KB;
    localparam int TSW   = CSW + KB;

    // Configuration registers.
    logic [IMG_W_CFG-1:0]  r_image_width;
    logic [IMG_H_CFG-1:0]  r_image_height;
    logic [CFG_DATA_W-1:0] r_weights_low;
    logic [CFG_DATA_W-1:0] r_weights_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_weights_low  <= RST_WEIGHTS_LOW;
            r_weights_high <= RST_WEIGHTS_HIGH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[IMG_W_CFG-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[IMG_H_CFG-1:0];
                CFG_WEIGHTS_LOW:  r_weights_low  <= i_cfg_wdata;
                CFG_WEIGHTS_HIGH: r_weights_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame size in use, clamped to what the kernel and the line buffer allow.
    logic [WCMP-1:0]      w_cfg;
    logic [WCW-1:0]       w_use;
    logic [IMG_H_CFG-1:0] h_use;

    always_comb begin
        w_cfg = WCMP'(r_image_width);
        if (w_cfg < WCMP'(K)) begin
            w_use = WCW'(K);
        end else if (w_cfg > WCMP'(MAX_WIDTH)) begin
            w_use = WCW'(MAX_WIDTH);
        end else begin
            w_use = WCW'(w_cfg);
        end
        if (r_image_height < IMG_H_CFG'(K)) begin
            h_use = IMG_H_CFG'(K);
        end else if (r_image_height > HEIGHT_LIMIT) begin
            h_use = HEIGHT_LIMIT;
        end else begin
            h_use = r_image_height;
        end
    end

    // Handshake: the pipeline moves whenever the skid stage is free.
    logic r_skid_valid;
    logic en;
    logic accept;

    assign en              = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    // Position counters and the position of the incoming pixel.
    logic [CW-1:0]        r_col;
    logic [ROW_W-1:0]     r_row;
    logic [CW-1:0]        col_eff;
    logic [ROW_W-1:0]     row_eff;
    logic [WCW-1:0]       col_inc;
    logic [IMG_H_CFG-1:0] row_inc;
    logic                 emit;
    logic                 last;

    always_comb begin
        if (i_s_axis_tuser || ({1'b0, r_col} >= w_use)) begin
            col_eff = '0;
        end else begin
            col_eff = r_col;
        end
        if (i_s_axis_tuser || ({1'b0, r_row} >= h_use)) begin
            row_eff = '0;
        end else begin
            row_eff = r_row;
        end
        col_inc = {1'b0, col_eff} + WCW'(1);
        row_inc = {1'b0, row_eff} + IMG_H_CFG'(1);
        emit    = ({1'b0, row_eff} >= IMG_H_CFG'(K - 1)) && ({1'b0, col_eff} >= WCW'(K - 1));
        last    = (row_inc == h_use) && (col_inc == w_use);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_inc >= w_use) begin
                r_col <= '0;
                r_row <= (row_inc >= h_use) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[CW-1:0];
                r_row <= row_eff;
            end
        end
    end

    // Stage one: pixel waits for its line buffer column.
    logic                    r1_valid;
    logic                    r1_emit;
    logic                    r1_last;
    logic [PIX_W-1:0]        r1_px;
    logic [CW-1:0]           r1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_emit <= emit;
            r1_last <= last;
            r1_px   <= i_s_axis_tdata[PIX_W-1:0];
            r1_col  <= col_eff;
        end
    end

    // Line buffer read and write; the new column is the stored rows plus the pixel.
    t_lb_ctrl                    lb_ctrl;
    logic [LANES-1:0][PIX_W-1:0] lb_rd_data;
    logic [K-1:0][PIX_W-1:0]     new_col;

    assign lb_ctrl.rd_en = en;
    assign lb_ctrl.wr_en = en && r1_valid;

    always_comb begin
        new_col[K-1]       = r1_px;
        new_col[LANES-1:0] = lb_rd_data;
    end

    c2d_linebuf #(
        .DEPTH (MAX_WIDTH),
        .LANES (LANES)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (lb_ctrl),
        .i_rd_addr (col_eff),
        .i_wr_addr (r1_col),
        .i_wr_data (new_col[K-1:1]),
        .o_rd_data (lb_rd_data)
    );

    // Result flags travel alongside the window, product and column sum stages.
    logic rw_valid, rp_valid, rc_valid;
    logic rw_last, rp_last, rc_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rw_valid <= 1'b0;
            rp_valid <= 1'b0;
            rc_valid <= 1'b0;
        end else if (en) begin
            rw_valid <= r1_valid && r1_emit;
            rp_valid <= rw_valid;
            rc_valid <= rp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rw_last <= r1_last;
            rp_last <= rw_last;
            rc_last <= rp_last;
        end
    end

    // Chain of window cells; the rightmost takes the new column.
    t_cell_ctrl                       cell_ctrl;
    logic [K-1:0][K-1:0][PIX_W-1:0]   cell_col;
    logic [K-1:0][CSW-1:0]            cell_csum;

    assign cell_ctrl.en    = en;
    assign cell_ctrl.shift = en && r1_valid;

    for (genvar x = 0; x < K; x++) begin : g_cell
        logic [K-1:0][WT_W-1:0]  wt;
        logic [K-1:0][PIX_W-1:0] col_in;

        always_comb begin
            for (int r = 0; r < K; r++) begin
                wt[r] = weight_at(r_weights_low, r_weights_high, r * K + x);
            end
        end

        if (x == K - 1) begin : g_edge
            assign col_in = new_col;
        end else begin : g_inner
            assign col_in = cell_col[x+1];
        end

        c2d_cell #(
            .KERNEL_DIM (K)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl),
            .i_col  (col_in),
            .i_wt   (wt),
            .o_col  (cell_col[x]),
            .o_csum (cell_csum[x])
        );
    end

    // Window total from the column sums.
    logic [TSW-1:0]         total;
    logic [OUT_TDATA_W-1:0] res_data;

    always_comb begin
        total = '0;
        for (int x = 0; x < K; x++) begin
            total = total + TSW'(cell_csum[x]);
        end
        res_data = OUT_TDATA_W'(SUM_W'(total));
    end

    // Output register with a skid stage behind it.
    logic                   r_out_valid;
    logic                   r_out_last;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_skid_last;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic                   out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (out_free && r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (out_free) begin
                r_out_valid  <= en && rc_valid;
            end else if (en && rc_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (out_free && r_skid_valid) begin
            r_out_data <= r_skid_data;
            r_out_last <= r_skid_last;
        end else if (out_free) begin
            r_out_data <= res_data;
            r_out_last <= rc_last;
        end else if (en && rc_valid) begin
            r_skid_data <= res_data;
            r_skid_last <= rc_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> design/c2d_checker.sv
// Port-level checks on the convolution top level, bound to every instance.
`timescale 1ns / 1ps

module c2d_checker
    import c2d_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tlast
);

    localparam logic [OUT_TDATA_W-1:0] SUM_MAX = 24'd1040400;

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // Input backpressure only while a result is waiting on the output.
    a_ready_low_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // Ready drops only after the output stalled with a result.
    a_ready_fall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready dropped without an output stall");

    // Sixteen byte products never exceed the sum range, and the padding stays zero.
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata <= SUM_MAX)
        else $error("result sum out of range");

endmodule

bind conv2d_4x4_valid_stream_top c2d_checker u_checker (.*);
